FILE: src/stxr_pkg.sv
// shared types, constants and helpers for the serial tx ring with crlf translation
package stxr_pkg;

   // ring size, a power of two so that the pointers wrap by plain overflow
   localparam int RING_DEPTH = 1024;
   localparam int PTR_W      = $clog2(RING_DEPTH);
   localparam int BANK_DEPTH = RING_DEPTH / 2;
   localparam int BANK_AW    = $clog2(BANK_DEPTH);

   localparam int BYTE_W     = 8;
   localparam int ACTION_W   = 2;
   localparam int FILL_W     = 10;
   localparam int FILL_MAX   = 1023;

   localparam logic [BYTE_W-1:0] CH_NUL = 8'h00;
   localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;

   typedef enum logic [ACTION_W-1:0] {
      ACT_ENQUEUE = 2'd0,
      ACT_TX_SLOT = 2'd1,
      ACT_RECEIVE = 2'd2
   } action_type;

   // result of one item
   typedef struct packed {
      logic              accepted;
      logic              tx_valid;
      logic [BYTE_W-1:0] tx_byte;
      logic              rx_valid;
      logic [BYTE_W-1:0] rx_byte;
      logic              rx_break;
      logic [FILL_W-1:0] fill_level;
   } result_type;

   // clamp the ring occupancy to the reported width
   function automatic logic [FILL_W-1:0] sat_fill(input logic [PTR_W-1:0] fill);
      logic [FILL_W-1:0] res;
      if (32'(fill) > FILL_MAX) begin
         res = FILL_W'(FILL_MAX);
      end else begin
         res = FILL_W'(fill);
      end
      return res;
   endfunction

endpackage

FILE: src/serial_tx_ring_crlf_translate.sv
// top level of the serial transmit ring with line feed expansion and receive translation
//
// Serial line-discipline block. Each item carries an action and a byte. An enqueue
// item stores its byte in a 1024-entry byte ring that holds up to 1023 bytes; a line
// feed is stored as a carriage return then a line feed and needs two free slots, a
// nul byte is dropped, and a byte without room is refused (rsp_accepted low) rather
// than waited on. A transmitter slot item pops the oldest byte when the ring is not
// empty. A receive item turns a carriage return into a line feed and reports a zero
// byte as a break. Action code 3 changes nothing. Every item gives exactly one result,
// with rsp_fill_level the ring occupancy after that item. One item is accepted every
// cycle while req_stall is low; a result passes the ring stage register, which takes
// the registered read of the ring memory, and then the output register before it is
// offered on the ports. The ring is split into an even and an odd bank so that the
// two bytes of an expanded line feed are written in the same cycle. Ring contents
// need no clearing after reset: only bytes between the pointers are ever read.
module serial_tx_ring_crlf_translate (
   input  logic                          clock,
   input  logic                          reset,
   // input item channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [stxr_pkg::ACTION_W-1:0] req_action,
   input  logic [stxr_pkg::BYTE_W-1:0]   req_byte_in,
   // result item channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_accepted,
   output logic                          rsp_tx_valid,
   output logic [stxr_pkg::BYTE_W-1:0]   rsp_tx_byte,
   output logic                          rsp_rx_valid,
   output logic [stxr_pkg::BYTE_W-1:0]   rsp_rx_byte,
   output logic                          rsp_rx_break,
   output logic [stxr_pkg::FILL_W-1:0]   rsp_fill_level
);
   import stxr_pkg::*;

   // handshake between ring stage and output register
   logic       advance;
   logic       s1_valid;
   result_type s1_result;
   result_type rsp_result;

   // pointers, banks and per-item decision
   stxr_ring u_ring (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_action  (req_action),
      .req_byte_in (req_byte_in),
      .advance     (advance),
      .s1_valid    (s1_valid),
      .s1_result   (s1_result)
   );

   // result register; while a stalled result waits it holds back the ring stage
   stxr_out u_out (
      .clock      (clock),
      .reset      (reset),
      .s1_valid   (s1_valid),
      .s1_result  (s1_result),
      .advance    (advance),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (rsp_result)
   );

   // unpack the result item onto its ports
   assign rsp_accepted   = rsp_result.accepted;
   assign rsp_tx_valid   = rsp_result.tx_valid;
   assign rsp_tx_byte    = rsp_result.tx_byte;
   assign rsp_rx_valid   = rsp_result.rx_valid;
   assign rsp_rx_byte    = rsp_result.rx_byte;
   assign rsp_rx_break   = rsp_result.rx_break;
   assign rsp_fill_level = rsp_result.fill_level;

endmodule

FILE: src/stxr_ram.sv
// generic single-write, single-read ram with registered read data
module stxr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/stxr_ring.sv
// ring pointers, two ram banks, per-item decision and the first result register
module stxr_ring (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [stxr_pkg::ACTION_W-1:0] req_action,
   input  logic [stxr_pkg::BYTE_W-1:0]   req_byte_in,
   input  logic                         advance,
   output logic                         s1_valid,
   output stxr_pkg::result_type         s1_result
);
   import stxr_pkg::*;

   logic                 accept;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     fill_ff, fill_in;
   logic [PTR_W-1:0]     wr_ptr_next1;
   logic                 push1, push2, pop;
   logic                 is_lf, is_nul;
   result_type           dec;
   logic                 s1_valid_ff, s1_valid_in;
   result_type           s1_ff;
   logic                 s1_bank_ff;

   logic                 bank_we   [2];
   logic [BANK_AW-1:0]   bank_wa   [2];
   logic [BYTE_W-1:0]    bank_wd   [2];
   logic [BYTE_W-1:0]    bank_rd   [2];

   assign req_stall = s1_valid_ff & ~advance;
   assign accept    = req_valid & ~req_stall;

   assign is_lf  = (req_byte_in == CH_LF);
   assign is_nul = (req_byte_in == CH_NUL);

   always_comb begin
      push1 = 1'b0;
      push2 = 1'b0;
      pop   = 1'b0;
      dec   = '0;
      unique case (action_type'(req_action))
         ACT_ENQUEUE: begin
            if (!is_nul) begin
               if (is_lf) begin
                  push2 = (fill_ff <= PTR_W'(RING_DEPTH - 3));
               end else begin
                  push1 = (fill_ff <= PTR_W'(RING_DEPTH - 2));
               end
            end
            dec.accepted = push1 | push2;
         end
         ACT_TX_SLOT: begin
            pop          = (fill_ff != '0);
            dec.tx_valid = pop;
         end
         ACT_RECEIVE: begin
            if (is_nul) begin
               dec.rx_break = 1'b1;
            end else begin
               dec.rx_valid = 1'b1;
               dec.rx_byte  = (req_byte_in == CH_CR) ? CH_LF : req_byte_in;
            end
         end
         default: begin
         end
      endcase

      wr_ptr_next1 = wr_ptr_ff + PTR_W'(1);
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      fill_in      = fill_ff;
      if (push2) begin
         wr_ptr_in = wr_ptr_ff + PTR_W'(2);
         fill_in   = fill_ff + PTR_W'(2);
      end else if (push1) begin
         wr_ptr_in = wr_ptr_next1;
         fill_in   = fill_ff + PTR_W'(1);
      end else if (pop) begin
         rd_ptr_in = rd_ptr_ff + PTR_W'(1);
         fill_in   = fill_ff - PTR_W'(1);
      end
      dec.fill_level = sat_fill(fill_in);

      // even addresses live in bank 0, odd in bank 1, so cr and lf never collide
      for (int b = 0; b < 2; b++) begin
         bank_we[b] = accept & (push2 | (push1 & (wr_ptr_ff[0] == 1'(b))));
         bank_wa[b] = (wr_ptr_ff[0] == 1'(b)) ? wr_ptr_ff[PTR_W-1:1]
                                              : wr_ptr_next1[PTR_W-1:1];
         if (push2) begin
            bank_wd[b] = (wr_ptr_ff[0] == 1'(b)) ? CH_CR : CH_LF;
         end else begin
            bank_wd[b] = req_byte_in;
         end
      end
   end

   for (genvar g = 0; g < 2; g++) begin : g_bank
      stxr_ram #(
         .WIDTH (BYTE_W),
         .DEPTH (BANK_DEPTH)
      ) u_bank (
         .clock   (clock),
         .wr_en   (bank_we[g]),
         .wr_addr (bank_wa[g]),
         .wr_data (bank_wd[g]),
         .rd_en   (accept & pop),
         .rd_addr (rd_ptr_ff[PTR_W-1:1]),
         .rd_data (bank_rd[g])
      );
   end

   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff   <= '0;
         wr_ptr_ff   <= '0;
         fill_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (accept) begin
            rd_ptr_ff <= rd_ptr_in;
            wr_ptr_ff <= wr_ptr_in;
            fill_ff   <= fill_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff      <= dec;
         s1_bank_ff <= rd_ptr_ff[0];
      end
   end

   // popped byte arrives from the bank in the cycle after the decision
   always_comb begin
      s1_result = s1_ff;
      if (s1_ff.tx_valid) begin
         s1_result.tx_byte = s1_bank_ff ? bank_rd[1] : bank_rd[0];
      end else begin
         s1_result.tx_byte = CH_NUL;
      end
   end

   assign s1_valid = s1_valid_ff;

endmodule

FILE: src/stxr_out.sv
// output result register, parts the result channel from the ring stage
module stxr_out (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 s1_valid,
   input  stxr_pkg::result_type s1_result,
   output logic                 advance,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output stxr_pkg::result_type rsp_result
);
   import stxr_pkg::*;

   logic       out_valid_ff, out_valid_in;
   result_type out_ff;

   assign advance      = ~out_valid_ff | ~rsp_stall;
   assign out_valid_in = advance ? s1_valid : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid) begin
         out_ff <= s1_result;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_result = out_ff;

endmodule

FILE: verif/tb_serial_tx_ring_crlf_translate.sv
// testbench for the serial transmit ring with line feed expansion and receive translation
`timescale 1ns / 1ps

module tb_serial_tx_ring_crlf_translate;
   import stxr_pkg::*;

   // action code with no meaning, the block must leave everything alone
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS    = 280;
   localparam int PRESSURE_CYCLES = 300;
   // random item count at which the ring is topped up to the brim
   localparam int BRIM_AT = 120;

   // flavour of a run of random items
   typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_type;

   // one row of the directed table; the result fields only count when known is set
   typedef struct packed {
      logic [ACTION_W-1:0] act;
      logic [BYTE_W-1:0]   data;
      logic                known;
      logic                acc;
      logic                txv;
      logic [BYTE_W-1:0]   txb;
      logic                rxv;
      logic [BYTE_W-1:0]   rxb;
      logic                brk;
      logic [FILL_W-1:0]   fill;
   } stim_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [ACTION_W-1:0] req_action = ACT_ENQUEUE;
   logic [BYTE_W-1:0]   req_byte_in = CH_NUL;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_accepted;
   logic                rsp_tx_valid;
   logic [BYTE_W-1:0]   rsp_tx_byte;
   logic                rsp_rx_valid;
   logic [BYTE_W-1:0]   rsp_rx_byte;
   logic                rsp_rx_break;
   logic [FILL_W-1:0]   rsp_fill_level;

   // shadow copy of the ring and its pointers, updated as each item is accepted
   logic [BYTE_W-1:0] shadow_ring [RING_DEPTH];
   logic [PTR_W-1:0]  shadow_rd = '0;
   logic [PTR_W-1:0]  shadow_wr = '0;

   // results still owed by the block, oldest first
   result_type pending_results [$];

   int   failures     = 0;
   int   results_seen = 0;
   int   send_calm    = 0;
   // long receiver hold-off, raised once by its own process
   logic hold_off     = 1'b0;

   // directed part: empty ring corners, receive translation, expansion, draining
   stim_row_type directed_rows [25] = '{
      // slot on an empty ring pops nothing, the byte is ignored
      '{ACT_TX_SLOT, 8'h00,  1'b1, 1'b0, 1'b0, 8'h00,  1'b0, 8'h00,  1'b0, 10'd0},
      '{ACT_TX_SLOT, 8'hFF,  1'b1, 1'b0, 1'b0, 8'h00,  1'b0, 8'h00,  1'b0, 10'd0},
      // zero on the line is a break, no byte delivered
      '{ACT_RECEIVE, CH_NUL, 1'b1, 1'b0, 1'b0, 8'h00,  1'b0, 8'h00,  1'b1, 10'd0},
      // carriage return comes up as a line feed
      '{ACT_RECEIVE, CH_CR,  1'b1, 1'b0, 1'b0, 8'h00,  1'b1, CH_LF,  1'b0, 10'd0},
      '{ACT_RECEIVE, 8'hFF,  1'b1, 1'b0, 1'b0, 8'h00,  1'b1, 8'hFF,  1'b0, 10'd0},
      '{ACT_RECEIVE, CH_LF,  1'b1, 1'b0, 1'b0, 8'h00,  1'b1, CH_LF,  1'b0, 10'd0},
      // nul is dropped on output
      '{ACT_ENQUEUE, CH_NUL, 1'b1, 1'b0, 1'b0, 8'h00,  1'b0, 8'h00,  1'b0, 10'd0},
      // line feed goes in as two bytes
      '{ACT_ENQUEUE, CH_LF,  1'b1, 1'b1, 1'b0, 8'h00,  1'b0, 8'h00,  1'b0, 10'd2},
      '{ACT_ENQUEUE, 8'hFF,  1'b1, 1'b1, 1'b0, 8'h00,  1'b0, 8'h00,  1'b0, 10'd3},
      '{ACT_ENQUEUE, 8'h01,  1'b1, 1'b1, 1'b0, 8'h00,  1'b0, 8'h00,  1'b0, 10'd4},
      // a carriage return on output is stored as it is
      '{ACT_ENQUEUE, CH_CR,  1'b1, 1'b1, 1'b0, 8'h00,  1'b0, 8'h00,  1'b0, 10'd5},
      // meaningless action leaves the ring alone
      '{ACT_UNUSED,  8'hAA,  1'b1, 1'b0, 1'b0, 8'h00,  1'b0, 8'h00,  1'b0, 10'd5},
      '{ACT_RECEIVE, CH_CR,  1'b1, 1'b0, 1'b0, 8'h00,  1'b1, CH_LF,  1'b0, 10'd5},
      // drain in order, then one slot too many
      '{ACT_TX_SLOT, 8'h00,  1'b1, 1'b0, 1'b1, CH_CR,  1'b0, 8'h00,  1'b0, 10'd4},
      '{ACT_TX_SLOT, 8'h00,  1'b1, 1'b0, 1'b1, CH_LF,  1'b0, 8'h00,  1'b0, 10'd3},
      '{ACT_TX_SLOT, 8'h00,  1'b1, 1'b0, 1'b1, 8'hFF,  1'b0, 8'h00,  1'b0, 10'd2},
      '{ACT_TX_SLOT, 8'h00,  1'b1, 1'b0, 1'b1, 8'h01,  1'b0, 8'h00,  1'b0, 10'd1},
      '{ACT_TX_SLOT, 8'h00,  1'b1, 1'b0, 1'b1, CH_CR,  1'b0, 8'h00,  1'b0, 10'd0},
      '{ACT_TX_SLOT, 8'h00,  1'b1, 1'b0, 1'b0, 8'h00,  1'b0, 8'h00,  1'b0, 10'd0},
      // mixed items, left to the shadow ring
      '{ACT_ENQUEUE, 8'h80,  1'b0, 1'b0, 1'b0, 8'h00,  1'b0, 8'h00,  1'b0, 10'd0},
      '{ACT_ENQUEUE, 8'h7F,  1'b0, 1'b0, 1'b0, 8'h00,  1'b0, 8'h00,  1'b0, 10'd0},
      '{ACT_TX_SLOT, 8'h55,  1'b0, 1'b0, 1'b0, 8'h00,  1'b0, 8'h00,  1'b0, 10'd0},
      '{ACT_UNUSED,  8'h00,  1'b0, 1'b0, 1'b0, 8'h00,  1'b0, 8'h00,  1'b0, 10'd0},
      '{ACT_TX_SLOT, 8'hAA,  1'b0, 1'b0, 1'b0, 8'h00,  1'b0, 8'h00,  1'b0, 10'd0},
      '{ACT_ENQUEUE, 8'h55,  1'b0, 1'b0, 1'b0, 8'h00,  1'b0, 8'h00,  1'b0, 10'd0}
   };

   serial_tx_ring_crlf_translate dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_byte_in    (req_byte_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_accepted   (rsp_accepted),
      .rsp_tx_valid   (rsp_tx_valid),
      .rsp_tx_byte    (rsp_tx_byte),
      .rsp_rx_valid   (rsp_rx_valid),
      .rsp_rx_byte    (rsp_rx_byte),
      .rsp_rx_break   (rsp_rx_break),
      .rsp_fill_level (rsp_fill_level)
   );

   always #4 clock = ~clock;

   // bytes held in the shadow ring, pointers wrap by plain overflow
   function automatic logic [PTR_W-1:0] ring_level();
      return shadow_wr - shadow_rd;
   endfunction

   function automatic void ring_push(input logic [BYTE_W-1:0] b);
      shadow_ring[shadow_wr] = b;
      shadow_wr = shadow_wr + 1'b1;
   endfunction

   // what one accepted item should produce, advancing the shadow ring
   function automatic result_type line_step(input logic [ACTION_W-1:0] act,
                                            input logic [BYTE_W-1:0]   b);
      result_type r;
      int         room;
      r    = '0;
      room = RING_DEPTH - 1 - int'(ring_level());
      case (act)
         ACT_ENQUEUE: begin
            // line feed needs room for the carriage return in front of it
            if (b == CH_LF) begin
               if (room >= 2) begin
                  ring_push(CH_CR);
                  ring_push(CH_LF);
                  r.accepted = 1'b1;
               end
            end else if (b != CH_NUL && room >= 1) begin
               ring_push(b);
               r.accepted = 1'b1;
            end
         end
         ACT_TX_SLOT: begin
            if (shadow_rd != shadow_wr) begin
               r.tx_valid = 1'b1;
               r.tx_byte  = shadow_ring[shadow_rd];
               shadow_rd  = shadow_rd + 1'b1;
            end
         end
         ACT_RECEIVE: begin
            if (b == CH_NUL) begin
               r.rx_break = 1'b1;
            end else begin
               r.rx_valid = 1'b1;
               r.rx_byte  = (b == CH_CR) ? CH_LF : b;
            end
         end
         default: ;
      endcase
      // a 1024 entry ring never holds more than the field can show
      r.fill_level = FILL_W'(ring_level());
      return r;
   endfunction

   // wait in cycles before the next item, with calm stretches of no waiting
   function automatic int draw_wait(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 9) == 0) begin
         calm_left = $urandom_range(8, 40);
         return 0;
      end
      return $urandom_range(0, 15);
   endfunction

   // byte content leaning on the characters the block treats specially
   function automatic logic [BYTE_W-1:0] pick_byte();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 6) return CH_NUL;
      if (roll < 20) return CH_LF;
      if (roll < 32) return CH_CR;
      if (roll < 36) return 8'hFF;
      return BYTE_W'($urandom_range(0, 255));
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         failures++;
         $display("%0t: %s mismatch, expected 'h%0h, got 'h%0h", $time, name, want, got);
      end
   endfunction

   // offer one item, wait for the handshake, then log what it should produce
   task automatic send_item(input logic [ACTION_W-1:0] act, input logic [BYTE_W-1:0] b,
                            input bit known, input result_type want);
      int         gap;
      result_type guess;
      // no gaps while the receiver is held off, so the block backs up
      gap = hold_off ? 0 : draw_wait(send_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_action  <= act;
      req_byte_in <= b;
      do @(posedge clock); while (req_stall);
      guess = line_step(act, b);
      pending_results.push_back(known ? want : guess);
      @(negedge clock);
   endtask

   initial begin : stimulus
      stim_row_type        row;
      result_type          want;
      phase_type           ph;
      logic [ACTION_W-1:0] act;
      int                  roll;
      int                  span;
      int                  done;
      int                  brims;
      done  = 0;
      brims = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row  = directed_rows[i];
         want = '{accepted: row.acc, tx_valid: row.txv, tx_byte: row.txb,
                  rx_valid: row.rxv, rx_byte: row.rxb, rx_break: row.brk,
                  fill_level: row.fill};
         send_item(row.act, row.data, row.known, want);
      end

      while (done < RANDOM_ITEMS) begin
         // once in the run, fill the ring to the brim and poke at the full cases
         if (brims == 0 && done >= BRIM_AT) begin
            brims++;
            // line feeds fill two slots at a time, plain bytes take the last ones
            while (ring_level() < RING_DEPTH - 3)
               send_item(ACT_ENQUEUE, CH_LF, 1'b0, '0);
            while (ring_level() < RING_DEPTH - 2)
               send_item(ACT_ENQUEUE, 8'h41, 1'b0, '0);
            // one slot free: line feed refused, a plain byte still fits
            send_item(ACT_ENQUEUE, CH_LF, 1'b0, '0);
            send_item(ACT_ENQUEUE, BYTE_W'($urandom_range(16, 255)), 1'b0, '0);
            // ring full: both enqueues refused, then a slot pops a byte
            send_item(ACT_ENQUEUE, pick_byte(), 1'b0, '0);
            send_item(ACT_ENQUEUE, CH_LF, 1'b0, '0);
            send_item(ACT_TX_SLOT, pick_byte(), 1'b0, '0);
         end
         ph   = phase_type'($urandom_range(0, 2));
         span = $urandom_range(20, 80);
         repeat (span) begin
            roll = $urandom_range(0, 99);
            case (ph)
               PH_FILL:
                  act = (roll < 75) ? ACT_ENQUEUE : (roll < 88) ? ACT_TX_SLOT :
                        (roll < 97) ? ACT_RECEIVE : ACT_UNUSED;
               PH_DRAIN:
                  act = (roll < 75) ? ACT_TX_SLOT : (roll < 88) ? ACT_ENQUEUE :
                        (roll < 97) ? ACT_RECEIVE : ACT_UNUSED;
               default:
                  act = (roll < 35) ? ACT_ENQUEUE : (roll < 70) ? ACT_TX_SLOT :
                        (roll < 95) ? ACT_RECEIVE : ACT_UNUSED;
            endcase
            send_item(act, pick_byte(), 1'b0, '0);
            done++;
         end
      end

      // all items in, let the last results drain out
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // result side: check at the rising edge, drive the stall at the falling edge
   initial begin : result_sink
      result_type want;
      int         wait_left;
      int         calm;
      wait_left = 0;
      calm      = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
               failures++;
               $display("%0t: result item with nothing expected, fill_level 'h%0h",
                        $time, rsp_fill_level);
            end else begin
               want = pending_results.pop_front();
               check_field("accepted",   want.accepted,   rsp_accepted);
               check_field("tx_valid",   want.tx_valid,   rsp_tx_valid);
               check_field("tx_byte",    want.tx_byte,    rsp_tx_byte);
               check_field("rx_valid",   want.rx_valid,   rsp_rx_valid);
               check_field("rx_byte",    want.rx_byte,    rsp_rx_byte);
               check_field("rx_break",   want.rx_break,   rsp_rx_break);
               check_field("fill_level", want.fill_level, rsp_fill_level);
            end
            wait_left = draw_wait(calm);
         end
         @(negedge clock);
         // outside the hold-off, stall cycles are only spent while a result is on offer
         if (hold_off) begin
            rsp_stall <= 1'b1;
         end else if (rsp_valid && wait_left > 0) begin
            rsp_stall <= 1'b1;
            wait_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // one long hold-off on the result side while the sender keeps offering items
   initial begin : back_pressure
      wait (results_seen >= 200);
      @(negedge clock);
      hold_off <= 1'b1;
      repeat (PRESSURE_CYCLES) @(negedge clock);
      hold_off <= 1'b0;
   end

   // give up well past the slowest legal run
   initial begin : watchdog
      #4000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

FILE: filelist.f
src/stxr_pkg.sv
src/stxr_ram.sv
src/stxr_ring.sv
src/stxr_out.sv
src/serial_tx_ring_crlf_translate.sv
verif/tb_serial_tx_ring_crlf_translate.sv
